// ----- rtl/ide_pkg.sv -----
// Package for the instruction dictionary encoder.
// Holds sizes, field widths, status and command codes, and shared types.
// No dependencies.
package ide_pkg;

    // Dictionary geometry.
    localparam int DICT_DEPTH = 256;
    localparam int WORD_WIDTH = 64;

    // Fixed port field widths.
    localparam int INSTR_W       = 64;
    localparam int CODE_W        = 8;
    localparam int CODE_BITS_W   = 4;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 9;

    // Derived widths.
    localparam int CNT_W = $clog2(DICT_DEPTH + 1);

    // Match reduction: cells are grouped, each group encodes its hit locally.
    localparam int GRP_SIZE   = 16;
    localparam int GRP_IDX_W  = $clog2(GRP_SIZE);
    localparam int NUM_GRP    = (DICT_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_SEL_W  = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
    localparam int PAD_DEPTH  = NUM_GRP * GRP_SIZE;
    localparam int PAD_IDX_W  = GRP_SEL_W + GRP_IDX_W;

    // Command codes.
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    // Registered result of one group of cells.
    typedef struct packed {
        logic                 any;
        logic [GRP_IDX_W-1:0] idx;
    } t_grp_res;

    // Number of bits needed to write n, never less than 1.
    function automatic logic [CODE_BITS_W-1:0] bits_for(input logic [CNT_W-1:0] n);
        logic [CODE_BITS_W-1:0] b;
        b = CODE_BITS_W'(1);
        for (int i = 1; i < CNT_W; i++) begin
            if (n[i]) begin
                b = CODE_BITS_W'(i + 1);
            end
        end
        return b;
    endfunction

endpackage

// ----- rtl/ide_cell.sv -----
// One dictionary cell: holds one word, shifts it on to its neighbor on insert,
// and registers whether its word matches the broadcast key. Uses ide_pkg.
module ide_cell (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic                          i_valid,
    input  logic [ide_pkg::WORD_WIDTH-1:0] i_word,
    input  logic [ide_pkg::WORD_WIDTH-1:0] i_key,
    output logic [ide_pkg::WORD_WIDTH-1:0] o_word,
    output logic                          o_hit
);
    import ide_pkg::*;

    logic [WORD_WIDTH-1:0] r_word;
    logic                  r_hit;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_word;
        end
        r_hit <= i_valid && (r_word == i_key);
    end

    assign o_word = r_word;
    assign o_hit  = r_hit;

endmodule

// ----- rtl/ide_group.sv -----
// Registered match encoder for one group of cells.
// Dictionary words are distinct, so at most one hit is set. Uses ide_pkg.
module ide_group (
    input  logic                         i_clk,
    input  logic [ide_pkg::GRP_SIZE-1:0] i_hits,
    output ide_pkg::t_grp_res            o_res
);
    import ide_pkg::*;

    t_grp_res r_res;
    t_grp_res n_res;

    always_comb begin
        n_res.any = |i_hits;
        n_res.idx = '0;
        for (int i = 0; i < GRP_SIZE; i++) begin
            if (i_hits[i]) begin
                n_res.idx = n_res.idx | GRP_IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ----- rtl/instruction_dictionary_encoder.sv -----
// Top level of the instruction dictionary encoder: a shifting row of cells,
// a registered group encoder and the command sequencer. Uses ide_pkg,
// ide_cell and ide_group.
//
//  channel   direction  signals                                   handshake
//  command   in         i_command, i_instruction_word             start, busy
//  result    out        o_code, o_code_bits, o_is_new,            o_valid
//                       o_status, o_entry_count
//
// A transaction accepted while idle steps through S_CMP, S_GRP and S_FIN,
// then gives its result strobe; busy falls in the strobe cycle. The path
// is registered at the cell compare, the group encoder and the outputs;
// the final encoder level is combinational. An insert shifts the whole row
// by one cell, so the newest word sits in cell 0. Reset clears the entry
// count and the sequencer; the cell contents need no clearing. The result
// strobe lasts one cycle and the receiver cannot stall it.
module instruction_dictionary_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_command,
    input  logic [ide_pkg::INSTR_W-1:0]       i_instruction_word,
    output logic                             o_valid,
    output logic [ide_pkg::CODE_W-1:0]        o_code,
    output logic [ide_pkg::CODE_BITS_W-1:0]   o_code_bits,
    output logic                             o_is_new,
    output logic [ide_pkg::STATUS_W-1:0]      o_status,
    output logic [ide_pkg::ENTRY_COUNT_W-1:0] o_entry_count
);
    import ide_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_GRP  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_cmd;
    logic [WORD_WIDTH-1:0]   r_key;

    logic                    r_valid;
    logic [CODE_W-1:0]       r_code;
    logic [CODE_BITS_W-1:0]  r_code_bits;
    logic                    r_is_new;
    t_status                 r_status;
    logic [ENTRY_COUNT_W-1:0] r_entry_count;

    logic [WORD_WIDTH-1:0]   words    [DICT_DEPTH];
    logic [WORD_WIDTH-1:0]   chain_in [DICT_DEPTH];
    logic [DICT_DEPTH-1:0]   cell_valid;
    logic [PAD_DEPTH-1:0]    hits;
    t_grp_res                grp      [NUM_GRP];

    logic                    accept;
    logic                    found;
    logic [PAD_IDX_W-1:0]    pos;
    logic                    full;
    logic                    insert;
    logic                    shift;
    logic [CNT_W-1:0]        idx;
    t_status                 status;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Row of cells; cell 0 takes the key on insert, the others their neighbor.
    for (genvar p = 0; p < DICT_DEPTH; p++) begin : g_cell
        if (p == 0) begin : g_head
            assign chain_in[p] = r_key;
        end else begin : g_body
            assign chain_in[p] = words[p-1];
        end
        assign cell_valid[p] = (CNT_W'(p) < r_count);

        ide_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (shift),
            .i_valid (cell_valid[p]),
            .i_word  (chain_in[p]),
            .i_key   (r_key),
            .o_word  (words[p]),
            .o_hit   (hits[p])
        );
    end

    if (PAD_DEPTH > DICT_DEPTH) begin : g_pad
        assign hits[PAD_DEPTH-1:DICT_DEPTH] = '0;
    end

    for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
        ide_group u_group (
            .i_clk  (i_clk),
            .i_hits (hits[g*GRP_SIZE +: GRP_SIZE]),
            .o_res  (grp[g])
        );
    end

    // Final level of the encoder and the command decision.
    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            if (grp[g].any) begin
                found = 1'b1;
                pos   = pos | {GRP_SEL_W'(g), grp[g].idx};
            end
        end

        full   = (r_count == CNT_W'(DICT_DEPTH));
        insert = 1'b0;
        idx    = '0;
        status = ST_OK;

        // The newest entry is in cell 0, so cell p holds index count-1-p.
        if (found) begin
            idx = r_count - CNT_W'(1) - CNT_W'(pos);
        end else if (r_cmd == CMD_ADD) begin
            if (!full) begin
                insert = 1'b1;
                idx    = r_count;
            end else begin
                status = ST_FULL;
            end
        end else begin
            status = ST_MISS;
        end

        n_count = insert ? (r_count + CNT_W'(1)) : r_count;
    end

    assign shift = (r_state == S_FIN) && insert;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_CMP;
            S_CMP:  n_state = S_GRP;
            S_GRP:  n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_FIN);
            if (r_state == S_FIN) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_key <= i_instruction_word[WORD_WIDTH-1:0];
        end
        if (r_state == S_FIN) begin
            r_code        <= CODE_W'(idx);
            r_code_bits   <= (n_count == '0) ? CODE_BITS_W'(1)
                                             : bits_for(n_count - CNT_W'(1));
            r_is_new      <= insert;
            r_status      <= status;
            r_entry_count <= ENTRY_COUNT_W'(n_count);
        end
    end

    assign o_valid       = r_valid;
    assign o_code        = r_code;
    assign o_code_bits   = r_code_bits;
    assign o_is_new      = r_is_new;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

`ifndef SYNTHESIS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a transaction is in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_new_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_new) |-> (o_status == ST_OK))
        else $error("new entry reported with an error status");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DICT_DEPTH))
        else $error("entry count beyond dictionary depth");
`endif

endmodule

// ----- tb/instruction_dictionary_encoder_tb.sv -----
// Self-checking testbench for instruction_dictionary_encoder: directed and random add and
// encode commands, checked field by field against a dictionary model kept in the bench.
// Depends on ide_pkg and the instruction_dictionary_encoder RTL.
`timescale 1ns / 100ps

module instruction_dictionary_encoder_tb;

    import ide_pkg::*;

    typedef struct {
        logic [CODE_W-1:0]        code;
        logic [CODE_BITS_W-1:0]   code_bits;
        logic                     is_new;
        t_status                  status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } t_encode_result;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     i_command = CMD_ADD;
    logic [INSTR_W-1:0]       i_instruction_word = '0;
    logic                     o_valid;
    logic [CODE_W-1:0]        o_code;
    logic [CODE_BITS_W-1:0]   o_code_bits;
    logic                     o_is_new;
    logic [STATUS_W-1:0]      o_status;
    logic [ENTRY_COUNT_W-1:0] o_entry_count;

    // Bench copy of the dictionary and the results still owed by the block.
    logic [WORD_WIDTH-1:0] dict_words [DICT_DEPTH];
    int unsigned           dict_count = 0;
    t_encode_result        expected_results [$];

    bit          gaps_on = 1'b1;
    int unsigned n_errors = 0;
    int unsigned n_results = 0;
    int unsigned n_adds = 0;
    int unsigned n_encodes = 0;
    int unsigned n_inserts = 0;
    int unsigned n_misses = 0;
    int unsigned n_full_rejects = 0;

    instruction_dictionary_encoder i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_command          (i_command),
        .i_instruction_word (i_instruction_word),
        .o_valid            (o_valid),
        .o_code             (o_code),
        .o_code_bits        (o_code_bits),
        .o_is_new           (o_is_new),
        .o_status           (o_status),
        .o_entry_count      (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("** instruction_dictionary_encoder: FAILED **");
        $finish;
    end

    // Bits needed to write n, never fewer than one.
    function automatic logic [CODE_BITS_W-1:0] code_width_for(input int unsigned n);
        int unsigned b;
        b = 1;
        while (b < 32 && (n >> b) != 0) begin
            b++;
        end
        return CODE_BITS_W'(b);
    endfunction

    // Applies one command to the bench dictionary and returns the result it must give.
    function automatic t_encode_result apply_command(input logic cmd,
                                                     input logic [INSTR_W-1:0] word);
        t_encode_result        r;
        logic [WORD_WIDTH-1:0] w;
        int unsigned           idx;
        bit                    found;
        w = word[WORD_WIDTH-1:0];
        idx = 0;
        found = 1'b0;
        for (int unsigned i = 0; i < dict_count; i++) begin
            if (!found && dict_words[i] == w) begin
                found = 1'b1;
                idx = i;
            end
        end
        r.code = '0;
        r.is_new = 1'b0;
        r.status = ST_OK;
        if (cmd == CMD_ADD) begin
            n_adds++;
            if (found) begin
                r.code = CODE_W'(idx);
            end else if (dict_count < DICT_DEPTH) begin
                dict_words[dict_count] = w;
                r.code = CODE_W'(dict_count);
                r.is_new = 1'b1;
                dict_count++;
                n_inserts++;
            end else begin
                r.status = ST_FULL;
                n_full_rejects++;
            end
        end else begin
            n_encodes++;
            if (found) begin
                r.code = CODE_W'(idx);
            end else begin
                r.status = ST_MISS;
                n_misses++;
            end
        end
        r.code_bits = (dict_count == 0) ? CODE_BITS_W'(1) : code_width_for(dict_count - 1);
        r.entry_count = ENTRY_COUNT_W'(dict_count);
        return r;
    endfunction

    // A stored word in known_pct percent of draws, one with a bit flipped in 15 percent more, the rest fresh.
    function automatic logic [INSTR_W-1:0] pick_word(input int unsigned known_pct);
        logic [INSTR_W-1:0] w;
        int unsigned        roll;
        roll = $urandom_range(99);
        if (dict_count != 0 && roll < known_pct) begin
            w = dict_words[$urandom_range(dict_count - 1)];
        end else if (dict_count != 0 && roll < known_pct + 15) begin
            w = dict_words[$urandom_range(dict_count - 1)]
                ^ (INSTR_W'(1) << $urandom_range(INSTR_W - 1));
        end else if (roll >= 90) begin
            w = INSTR_W'($urandom_range(15));
        end else begin
            w = {$urandom, $urandom};
        end
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // Start stays high from one transaction to the next unless a gap is inserted.
    task automatic send_word(input logic cmd, input logic [INSTR_W-1:0] word);
        int unsigned gap;
        gap = 0;
        if (gaps_on && $urandom_range(99) < 32) begin
            gap = $urandom_range(6, 1);
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_instruction_word <= word;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        expected_results.push_back(apply_command(cmd, word));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_encode_result exp_r;
        if (i_rst_n && o_valid === 1'b1) begin
            n_results++;
            if (expected_results.size() == 0) begin
                $error("result with no transaction outstanding: code 0x%0h status %0d",
                       o_code, o_status);
                n_errors++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("code", exp_r.code, o_code);
                check_field("code_bits", exp_r.code_bits, o_code_bits);
                check_field("is_new", exp_r.is_new, o_is_new);
                check_field("status", exp_r.status, o_status);
                check_field("entry_count", exp_r.entry_count, o_entry_count);
            end
        end
    end

    // Lookups before anything is stored must miss with a code width of one.
    task automatic test_empty_dictionary();
        send_word(CMD_ENCODE, '0);
        send_word(CMD_ENCODE, '1);
    endtask

    task automatic test_directed_words();
        send_word(CMD_ADD, '0);
        send_word(CMD_ADD, '0);
        send_word(CMD_ENCODE, '0);
        send_word(CMD_ADD, '1);
        send_word(CMD_ADD, 64'h8000_0000_0000_0000);
        send_word(CMD_ADD, 64'h0000_0000_0000_0001);
        send_word(CMD_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(CMD_ADD, 64'h5555_5555_5555_5555);
        send_word(CMD_ENCODE, '1);
        send_word(CMD_ENCODE, 64'h8000_0000_0000_0000);
        send_word(CMD_ENCODE, 64'h0000_0000_0000_0001);
        send_word(CMD_ENCODE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(CMD_ENCODE, 64'h5555_5555_5555_5555);
        // Near misses of stored words must not match.
        send_word(CMD_ENCODE, 64'h0000_0000_0000_0002);
        send_word(CMD_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF);
        send_word(CMD_ENCODE, 64'hAAAA_AAAA_AAAA_AAAB);
        send_word(CMD_ADD, '1);
        send_word(CMD_ADD, 64'h8000_0000_0000_0000);
    endtask

    // Mixed traffic while the dictionary grows through each code width.
    task automatic test_random_growth();
        for (int i = 0; i < 500; i++) begin
            gaps_on = !(i >= 150 && i < 320);
            if ($urandom_range(99) < 55) begin
                send_word(CMD_ADD, pick_word(40));
            end else begin
                send_word(CMD_ENCODE, pick_word(60));
            end
        end
        gaps_on = 1'b1;
    endtask

    // Fill every entry, then add and look up against a full dictionary.
    task automatic test_full_dictionary();
        while (dict_count < DICT_DEPTH) begin
            send_word(CMD_ADD, pick_word(0));
        end
        for (int i = 0; i < 260; i++) begin
            if ($urandom_range(99) < 55) begin
                send_word(CMD_ADD, pick_word(50));
            end else begin
                send_word(CMD_ENCODE, pick_word(60));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_dictionary();
        test_directed_words();
        test_random_growth();
        drain_results();
        test_full_dictionary();
        drain_results();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d adds (%0d inserts, %0d refused as full) and %0d encodes",
                 n_adds, n_inserts, n_full_rejects, n_encodes);
        $display("with %0d misses; %0d results checked, %0d entries at the end.",
                 n_misses, n_results, dict_count);
        if (n_errors == 0) begin
            $display("** instruction_dictionary_encoder: PASSED **");
        end else begin
            $display("** instruction_dictionary_encoder: FAILED **");
        end
        $finish;
    end

endmodule
